>>> design/dpc_pkg.sv
// Shared types and constants for the packet capture parser.
package dpc_pkg;

   // Configuration reset value
   localparam logic [15:0] MATCH_PORT_RESET = 16'd53;

   // Protocol codes
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [2:0]  IP_VER_4      = 3'd4;
   localparam logic [2:0]  IP_VER_6      = 3'd6;

   // Result transaction kinds and metadata word numbers
   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_META    = 1'b1;
   localparam logic [2:0] WORD_TIME    = 3'd0;
   localparam logic [2:0] WORD_LAST    = 3'd5;

   // Events handed from the parser to the output stage
   typedef struct packed {
      logic                  pay_vld;
      logic [7:0]            pay_byte;
      logic                  rec_vld;
      logic [63:0]           rec_time;
      logic [63:0]           rec_hdr;
      logic [3:0][63:0]      rec_addr;
   } dpc_evt_type;

endpackage

>>> design/dpc_parser.sv
// Byte-wise Ethernet, IP and L4 header parser with port match.
module dpc_parser #(
   parameter int MAX_PAYLOAD = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_fire,
   input  logic [7:0]          frame_byte,
   input  logic                frame_end,
   input  logic [63:0]         time_ns,
   input  logic [15:0]         match_port,
   output logic                may_output,
   output dpc_pkg::dpc_evt_type evt
);
   import dpc_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   localparam logic [2:0] PH_ETH = 3'd0;
   localparam logic [2:0] PH_IP4 = 3'd1;
   localparam logic [2:0] PH_IP6 = 3'd2;
   localparam logic [2:0] PH_L4  = 3'd3;
   localparam logic [2:0] PH_PAY = 3'd4;

   logic [15:0]      off_ff, off_in;
   logic [2:0]       phase_ff, phase_in;
   logic [15:0]      ek_ff, ek_in;
   logic [2:0]       ver_ff, ver_in;
   logic [7:0]       proto_ff, proto_in;
   logic [6:0]       l4s_ff, l4s_in;
   logic [15:0]      psrc_ff, psrc_in;
   logic [15:0]      pdst_ff, pdst_in;
   logic [3:0][63:0] addr_ff, addr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rej_ff, rej_in;

   logic [15:0] ek_new;
   logic [15:0] rel;
   logic [15:0] hlen_m1;
   logic [15:0] v6_rel;
   logic [1:0]  aw_sel;
   logic        emit_pay;

   assign ek_new  = {ek_ff[7:0], frame_byte};
   assign rel     = off_ff - {9'd0, l4s_ff};
   assign hlen_m1 = (proto_ff == PROTO_UDP) ? 16'd7 : 16'd19;
   assign v6_rel  = off_ff - 16'd22;
   assign aw_sel  = v6_rel[4:3];

   // Only the payload phase of a live frame can produce results
   assign may_output = !rej_ff && (phase_ff == PH_PAY);

   // Work out the next parse state for the byte on the input
   always_comb begin
      off_in   = off_ff;
      phase_in = phase_ff;
      ek_in    = ek_ff;
      ver_in   = ver_ff;
      proto_in = proto_ff;
      l4s_in   = l4s_ff;
      psrc_in  = psrc_ff;
      pdst_in  = pdst_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      rej_in   = rej_ff;
      emit_pay = 1'b0;

      if (!rej_ff) begin
         case (phase_ff)
            PH_ETH: begin
               if (off_ff == 16'd12 || off_ff == 16'd13) begin
                  ek_in = ek_new;
               end
               if (off_ff == 16'd13) begin
                  if (ek_new == ETH_TYPE_IPV4) begin
                     phase_in = PH_IP4;
                     ver_in   = IP_VER_4;
                  end else if (ek_new == ETH_TYPE_IPV6) begin
                     phase_in = PH_IP6;
                     ver_in   = IP_VER_6;
                     l4s_in   = 7'd54;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
            PH_IP4: begin
               if (off_ff == 16'd14) begin
                  if (frame_byte[3:0] < 4'd5) begin
                     rej_in = 1'b1;
                  end
                  l4s_in = 7'd14 + {1'b0, frame_byte[3:0], 2'b00};
               end else if (off_ff == 16'd23) begin
                  proto_in = frame_byte;
                  if (frame_byte != PROTO_TCP && frame_byte != PROTO_UDP) begin
                     rej_in = 1'b1;
                  end
               end else if (off_ff >= 16'd26 && off_ff <= 16'd29) begin
                  addr_in[0] = {addr_ff[0][55:0], frame_byte};
               end else if (off_ff >= 16'd30 && off_ff <= 16'd33) begin
                  addr_in[1] = {addr_ff[1][55:0], frame_byte};
               end
               if (off_ff >= 16'd33 && ({1'b0, off_ff} + 17'd1) == {10'd0, l4s_ff}) begin
                  phase_in = PH_L4;
               end
            end
            PH_IP6: begin
               if (off_ff == 16'd20) begin
                  proto_in = frame_byte;
                  if (frame_byte != PROTO_TCP && frame_byte != PROTO_UDP) begin
                     rej_in = 1'b1;
                  end
               end else if (off_ff >= 16'd22 && off_ff <= 16'd53) begin
                  addr_in[aw_sel] = {addr_ff[aw_sel][55:0], frame_byte};
               end
               if (off_ff == 16'd53) begin
                  phase_in = PH_L4;
               end
            end
            PH_L4: begin
               if (rel < 16'd2) begin
                  psrc_in = {psrc_ff[7:0], frame_byte};
               end else if (rel < 16'd4) begin
                  pdst_in = {pdst_ff[7:0], frame_byte};
               end
               if (rel == hlen_m1) begin
                  if (psrc_ff != match_port && pdst_ff != match_port) begin
                     rej_in = 1'b1;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               if (cnt_ff < CNT_W'(MAX_PAYLOAD)) begin
                  emit_pay = 1'b1;
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
            default: begin
               rej_in = 1'b1;
            end
         endcase
      end

      // Saturate the byte offset on very long frames
      if (off_ff != 16'hFFFF) begin
         off_in = off_ff + 16'd1;
      end
   end

   // Build the events for the output stage
   always_comb begin
      evt.pay_vld  = in_fire && emit_pay;
      evt.pay_byte = frame_byte;
      evt.rec_vld  = in_fire && frame_end && !rej_in && (phase_in == PH_PAY)
                     && (cnt_in != '0);
      evt.rec_time = time_ns;
      evt.rec_hdr  = {16'(cnt_in), pdst_ff, psrc_ff, proto_ff, 5'd0, ver_ff};
      evt.rec_addr = addr_ff;
   end

   // Advance the parse state, clearing it after the final byte
   always_ff @(posedge clock) begin
      if (reset || (in_fire && frame_end)) begin
         off_ff   <= '0;
         phase_ff <= PH_ETH;
         ek_ff    <= '0;
         ver_ff   <= '0;
         proto_ff <= '0;
         l4s_ff   <= '0;
         psrc_ff  <= '0;
         pdst_ff  <= '0;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         rej_ff   <= 1'b0;
      end else if (in_fire) begin
         off_ff   <= off_in;
         phase_ff <= phase_in;
         ek_ff    <= ek_in;
         ver_ff   <= ver_in;
         proto_ff <= proto_in;
         l4s_ff   <= l4s_in;
         psrc_ff  <= psrc_in;
         pdst_ff  <= pdst_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
         rej_ff   <= rej_in;
      end
   end

endmodule

>>> design/dpc_out.sv
// Result register for payload bytes and the six-word metadata record.
module dpc_out (
   input  logic                 clock,
   input  logic                 reset,
   input  dpc_pkg::dpc_evt_type evt,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);
   import dpc_pkg::*;

   logic             pay_vld_ff, pay_vld_in;
   logic [7:0]       pay_byte_ff;
   logic             rec_act_ff, rec_act_in;
   logic [2:0]       rec_idx_ff, rec_idx_in;
   logic [63:0]      rec_time_ff;
   logic [63:0]      rec_hdr_ff;
   logic [3:0][63:0] rec_addr_ff;

   logic        take;
   logic        pay_take;
   logic        rec_take;
   logic        rec_done;
   logic [63:0] word;

   // Payload byte goes ahead of any record waiting behind it
   assign rsp_tvalid = pay_vld_ff || rec_act_ff;
   assign take       = rsp_tvalid && rsp_tready;
   assign pay_take   = take && pay_vld_ff;
   assign rec_take   = take && !pay_vld_ff && rec_act_ff;
   assign rec_done   = rec_take && (rec_idx_ff == WORD_LAST);
   assign out_free   = (!pay_vld_ff || pay_take) && (!rec_act_ff || rec_done);

   // Select the metadata word
   always_comb begin
      case (rec_idx_ff)
         3'd0:    word = rec_time_ff;
         3'd1:    word = rec_hdr_ff;
         3'd2:    word = rec_addr_ff[0];
         3'd3:    word = rec_addr_ff[1];
         3'd4:    word = rec_addr_ff[2];
         default: word = rec_addr_ff[3];
      endcase
   end

   // Drive the result transaction
   always_comb begin
      if (pay_vld_ff) begin
         rsp_tdata = {5'd0, WORD_TIME, 56'd0, pay_byte_ff};
         rsp_tuser = KIND_PAYLOAD;
         rsp_tlast = 1'b0;
      end else begin
         rsp_tdata = {5'd0, rec_idx_ff, word};
         rsp_tuser = KIND_META;
         rsp_tlast = rec_act_ff && (rec_idx_ff == WORD_LAST);
      end
   end

   // Next control state
   always_comb begin
      pay_vld_in = pay_vld_ff;
      rec_act_in = rec_act_ff;
      rec_idx_in = rec_idx_ff;
      if (evt.pay_vld) begin
         pay_vld_in = 1'b1;
      end else if (pay_take) begin
         pay_vld_in = 1'b0;
      end
      if (evt.rec_vld) begin
         rec_act_in = 1'b1;
         rec_idx_in = WORD_TIME;
      end else if (rec_done) begin
         rec_act_in = 1'b0;
      end else if (rec_take) begin
         rec_idx_in = rec_idx_ff + 3'd1;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pay_vld_ff <= 1'b0;
         rec_act_ff <= 1'b0;
         rec_idx_ff <= WORD_TIME;
      end else begin
         pay_vld_ff <= pay_vld_in;
         rec_act_ff <= rec_act_in;
         rec_idx_ff <= rec_idx_in;
      end
   end

   // Capture payload and record snapshot
   always_ff @(posedge clock) begin
      if (evt.pay_vld) begin
         pay_byte_ff <= evt.pay_byte;
      end
      if (evt.rec_vld) begin
         rec_time_ff <= evt.rec_time;
         rec_hdr_ff  <= evt.rec_hdr;
         rec_addr_ff <= evt.rec_addr;
      end
   end

   a_pay_room: assert property (@(posedge clock) disable iff (reset)
      evt.pay_vld |-> (!pay_vld_ff || pay_take))
      else $error("payload byte loaded over an untaken one");

   a_rec_room: assert property (@(posedge clock) disable iff (reset)
      evt.rec_vld |-> (!rec_act_ff || rec_done))
      else $error("record loaded while another is still draining");

   a_last_meta: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_META && rec_idx_ff == WORD_LAST))
      else $error("tlast on something other than the final metadata word");

   a_word_step: assert property (@(posedge clock) disable iff (reset)
      (rec_take && !rec_done && !evt.rec_vld) |=>
         (rec_idx_ff == 3'($past(rec_idx_ff) + 3'd1)))
      else $error("metadata word sequence skipped or repeated");

endmodule

>>> design/dns_packet_capture_parser.sv
// Top level of the packet capture parser: config register, parser and result stage.
//
// Frame bytes enter on the req_ stream, one byte per transaction, with req_tlast
// on the final byte of each frame. Results leave on the rsp_ stream: rsp_tuser
// low marks a payload byte, high a metadata word; rsp_tlast marks the sixth and
// final word of a record. csr_wr_en writes the match port from csr_wr_data.
//
// A frame byte is parsed in the cycle it is accepted. A payload byte appears on
// rsp_ in the cycle after its transaction; a record follows the final byte's own
// payload byte, if any, as six words from the single result register, one word
// per transaction. One byte is accepted every cycle while parsing headers.
// During the payload phase a byte is taken only once the result register has
// room, so with rsp_tready held high the block runs at one byte per cycle.
//
// Reset (synchronous, active high) clears the parse state, drops any pending
// results and sets the match port to 53. When the receiver stalls, results are
// held and header bytes are still taken; payload bytes wait on req_tready.
module dns_packet_capture_parser #(
   parameter int MAX_PAYLOAD = 512
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Frame byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] frame_byte, [71:8] time_ns
   input  logic        req_tlast,   // frame_end
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] item_data, [66:64] word_index, [71:67] zero
   output logic        rsp_tuser,   // item_kind
   output logic        rsp_tlast    // record_last
);
   import dpc_pkg::*;

   logic        match_port_ff;
   logic [15:0] match_port_q_ff;
   logic [15:0] match_port_q_in;
   logic        in_fire;
   logic        may_output;
   logic        out_free;
   dpc_evt_type evt;

   // Take a byte unless it may produce a result that has no room
   assign req_tready = !may_output || out_free;
   assign in_fire    = req_tvalid && req_tready;

   // Match port register
   assign match_port_q_in = csr_wr_en ? csr_wr_data : match_port_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_port_q_ff <= MATCH_PORT_RESET;
         match_port_ff   <= 1'b0;
      end else begin
         match_port_q_ff <= match_port_q_in;
         match_port_ff   <= csr_wr_en;
      end
   end

   dpc_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (in_fire),
      .frame_byte (req_tdata[7:0]),
      .frame_end  (req_tlast),
      .time_ns    (req_tdata[71:8]),
      .match_port (match_port_q_ff),
      .may_output (may_output),
      .evt        (evt)
   );

   dpc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A configuration write lands in the register on the next cycle
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      match_port_ff |-> (match_port_q_ff == $past(csr_wr_data)))
      else $error("match port write lost");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !in_fire) |=> rsp_tvalid)
      else $error("result dropped under back-pressure");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      (in_fire && may_output) |-> out_free)
      else $error("byte taken with no room for its results");

endmodule

>>> dv/dpc_capture_checker.sv
`timescale 1ns / 1ps
// Checker for the packet capture parser: predicts the captures of each frame byte and compares.
module dpc_capture_checker #(
   parameter int MAX_PAYLOAD = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] frame_byte, [71:8] time_ns
   input  logic        req_tlast,   // frame_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // [63:0] item_data, [66:64] word_index, [71:67] zero
   input  logic        rsp_tuser,   // item_kind
   input  logic        rsp_tlast,   // record_last
   output int          captures_outstanding,
   output int          mismatch_count
);
   import dpc_pkg::*;

   localparam logic [2:0] WORD_NONE = 3'd0;   // word number carried by a payload byte
   localparam logic [2:0] WORD_HDR  = 3'd1;
   localparam logic [2:0] WORD_ADDR = 3'd2;   // first of the four address words

   typedef enum logic [2:0] {
      STAGE_ETHER,
      STAGE_IPV4,
      STAGE_IPV6,
      STAGE_TRANSPORT,
      STAGE_PAYLOAD
   } parse_stage_type;

   typedef struct {
      logic        kind;
      logic [63:0] data;
      logic [2:0]  index;
      logic        last;
   } capture_item_type;

   // Predicted parser state
   logic [15:0]      match_port_q;
   logic [15:0]      frame_offset;
   parse_stage_type  stage;
   logic [15:0]      ether_type;
   logic [2:0]       ver_seen;
   logic [7:0]       l4_proto;
   logic [15:0]      l4_base;
   logic [15:0]      sport_seen;
   logic [15:0]      dport_seen;
   logic [63:0]      addr_word [4];
   logic [15:0]      payload_taken;
   logic             frame_dropped;
   capture_item_type capture_due [$];

   initial begin
      mismatch_count       = 0;
      captures_outstanding = 0;
   end

   function automatic void clear_frame_state();
      frame_offset  = '0;
      stage         = STAGE_ETHER;
      ether_type    = '0;
      ver_seen      = '0;
      l4_proto      = '0;
      l4_base       = '0;
      sport_seen    = '0;
      dport_seen    = '0;
      payload_taken = '0;
      frame_dropped = 1'b0;
      for (int i = 0; i < 4; i++) addr_word[i] = '0;
   endfunction

   function automatic void expect_item(input logic kind, input logic [63:0] data,
                                       input logic [2:0] index, input logic last);
      capture_item_type item;
      item.kind  = kind;
      item.data  = data;
      item.index = index;
      item.last  = last;
      capture_due.push_back(item);
   endfunction

   // Advance the predicted parser by one accepted frame byte
   function automatic void parse_frame_byte(input logic [7:0] b, input logic last_byte,
                                            input logic [63:0] stamp);
      int unsigned off;
      int unsigned rel;
      int unsigned hdr_len;
      off = frame_offset;
      if (!frame_dropped) begin
         case (stage)
            STAGE_ETHER: begin
               if (off == 12 || off == 13) ether_type = {ether_type[7:0], b};
               if (off == 13) begin
                  if (ether_type == ETH_TYPE_IPV4) begin
                     stage    = STAGE_IPV4;
                     ver_seen = IP_VER_4;
                  end else if (ether_type == ETH_TYPE_IPV6) begin
                     stage    = STAGE_IPV6;
                     ver_seen = IP_VER_6;
                     l4_base  = 16'd54;
                  end else begin
                     frame_dropped = 1'b1;
                  end
               end
            end
            STAGE_IPV4: begin
               // IHL sets where the transport header starts
               if (off == 14) begin
                  if (b[3:0] < 4'd5) frame_dropped = 1'b1;
                  l4_base = 16'd14 + {10'd0, b[3:0], 2'b00};
               end else if (off == 23) begin
                  l4_proto = b;
                  if (b != PROTO_TCP && b != PROTO_UDP) frame_dropped = 1'b1;
               end else if (off >= 26 && off <= 29) begin
                  addr_word[0] = {addr_word[0][55:0], b};
               end else if (off >= 30 && off <= 33) begin
                  addr_word[1] = {addr_word[1][55:0], b};
               end
               if (off >= 33 && off + 1 == l4_base) stage = STAGE_TRANSPORT;
            end
            STAGE_IPV6: begin
               if (off == 20) begin
                  l4_proto = b;
                  if (b != PROTO_TCP && b != PROTO_UDP) frame_dropped = 1'b1;
               end else if (off >= 22 && off <= 53) begin
                  addr_word[(off - 22) >> 3] = {addr_word[(off - 22) >> 3][55:0], b};
               end
               if (off == 53) stage = STAGE_TRANSPORT;
            end
            STAGE_TRANSPORT: begin
               // Collect the ports, then decide on capture at the header's last byte
               rel     = (off - l4_base) & 32'hFFFF;
               hdr_len = (l4_proto == PROTO_UDP) ? 8 : 20;
               if (rel < 2) sport_seen = {sport_seen[7:0], b};
               else if (rel < 4) dport_seen = {dport_seen[7:0], b};
               if (rel + 1 == hdr_len) begin
                  if (sport_seen != match_port_q && dport_seen != match_port_q)
                     frame_dropped = 1'b1;
                  else
                     stage = STAGE_PAYLOAD;
               end
            end
            STAGE_PAYLOAD: begin
               if (payload_taken < MAX_PAYLOAD) begin
                  expect_item(KIND_PAYLOAD, {56'd0, b}, WORD_NONE, 1'b0);
                  payload_taken++;
               end
            end
            default: frame_dropped = 1'b1;
         endcase
      end

      if (frame_offset != 16'hFFFF) frame_offset++;

      // Emit the record on the final byte of a captured frame
      if (last_byte) begin
         if (!frame_dropped && stage == STAGE_PAYLOAD && payload_taken != 0) begin
            expect_item(KIND_META, stamp, WORD_TIME, 1'b0);
            expect_item(KIND_META, {payload_taken, dport_seen, sport_seen, l4_proto,
                                    5'd0, ver_seen}, WORD_HDR, 1'b0);
            for (int i = 0; i < 4; i++)
               expect_item(KIND_META, addr_word[i], WORD_ADDR + 3'(i), i == 3);
         end
         clear_frame_state();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] wanted);
      $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, wanted);
      mismatch_count++;
   endtask

   // Compare each result transaction, then predict from each frame byte transaction
   always @(posedge clock) begin : watch_channels
      capture_item_type want;
      if (reset) begin
         match_port_q = MATCH_PORT_RESET;
         clear_frame_state();
         capture_due.delete();
      end else begin
         if (csr_wr_en) match_port_q = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (capture_due.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_tdata[63:0], '0);
            end else begin
               want = capture_due.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("item kind", 64'(rsp_tuser), 64'(want.kind));
               if (rsp_tdata[63:0] !== want.data)
                  report_mismatch("item data", rsp_tdata[63:0], want.data);
               if (rsp_tdata[66:64] !== want.index)
                  report_mismatch("word index", 64'(rsp_tdata[66:64]), 64'(want.index));
               if (rsp_tlast !== want.last)
                  report_mismatch("record last", 64'(rsp_tlast), 64'(want.last));
               if (rsp_tdata[71:67] !== 5'd0)
                  report_mismatch("padding bits", 64'(rsp_tdata[71:67]), '0);
            end
         end
         if (req_tvalid && req_tready)
            parse_frame_byte(req_tdata[7:0], req_tlast, req_tdata[71:8]);
      end
      captures_outstanding <= capture_due.size();
   end

endmodule

>>> dv/tb_dns_packet_capture_parser.sv
`timescale 1ns / 1ps
// Testbench top for the packet capture parser: clock, reset, frame stimulus and verdict.
module tb_dns_packet_capture_parser;
   import dpc_pkg::*;

   localparam int          MAX_PAYLOAD   = 512;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          DRAIN_CYCLES  = 24;
   localparam int          LONG_STALL    = 600;
   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic [71:0] req_tdata   = '0;   // [7:0] frame_byte, [71:8] time_ns
   logic        req_tlast   = 1'b0; // frame_end
   logic        rsp_tready  = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [71:0] rsp_tdata;          // [63:0] item_data, [66:64] word_index, [71:67] zero
   logic        rsp_tuser;          // item_kind
   logic        rsp_tlast;          // record_last

   int          captures_outstanding;
   int          mismatch_count;
   int          cycle_count       = 0;
   int          sender_idle_pct   = 0;
   int          receiver_idle_pct = 0;
   int          stall_asked       = 0;
   int          stall_served      = 0;
   int          stall_left        = 0;
   logic [15:0] match_port        = MATCH_PORT_RESET;
   logic [7:0]  frame_bytes [$];

   dns_packet_capture_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   dpc_capture_checker #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) capture_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .req_tlast            (req_tlast),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .rsp_tuser            (rsp_tuser),
      .rsp_tlast            (rsp_tlast),
      .captures_outstanding (captures_outstanding),
      .mismatch_count       (mismatch_count)
   );

   always #2 clock = ~clock;

   // Abandon a run that never drains
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus a long hold-off when one is asked for
   always @(posedge clock) begin
      if (stall_asked != stall_served) begin
         stall_served = stall_asked;
         stall_left   = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one frame byte, with random gaps beforehand, and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last_byte,
                            input logic [63:0] stamp);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, b};
      req_tlast  <= last_byte;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted capture has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (captures_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_match_port(input logic [15:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      match_port  = value;
   endtask

   // Assemble an Ethernet frame; the layout follows the EtherType
   task automatic build_frame(input logic [15:0] ether_type, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [15:0] sport,
                              input logic [15:0] dport, input int pay_len);
      frame_bytes.delete();
      repeat (12) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(ether_type[15:8]);
      frame_bytes.push_back(ether_type[7:0]);
      if (ether_type == ETH_TYPE_IPV4) begin
         // version nibble left random, it is not checked
         frame_bytes.push_back({4'($urandom), ihl});
         repeat (8) frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(proto);
         repeat (10) frame_bytes.push_back(8'($urandom));
         if (ihl > 4'd5) repeat ((ihl - 5) * 4) frame_bytes.push_back(8'($urandom));
      end else if (ether_type == ETH_TYPE_IPV6) begin
         repeat (6) frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(proto);
         repeat (33) frame_bytes.push_back(8'($urandom));
      end else begin
         repeat (40) frame_bytes.push_back(8'($urandom));
      end
      frame_bytes.push_back(sport[15:8]);
      frame_bytes.push_back(sport[7:0]);
      frame_bytes.push_back(dport[15:8]);
      frame_bytes.push_back(dport[7:0]);
      repeat (proto == PROTO_TCP ? 16 : 4) frame_bytes.push_back(8'($urandom));
      repeat (pay_len) frame_bytes.push_back(8'($urandom));
   endtask

   // Send the first keep bytes of the assembled frame, the last one marked
   task automatic send_frame(input int keep, input logic [63:0] end_stamp);
      for (int i = 0; i < keep; i++)
         send_byte(frame_bytes[i], i == keep - 1, (i == keep - 1) ? end_stamp : rand64());
   endtask

   task automatic send_full(input logic [15:0] ether_type, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [15:0] sport,
                            input logic [15:0] dport, input int pay_len,
                            input logic [63:0] end_stamp);
      build_frame(ether_type, ihl, proto, sport, dport, pay_len);
      send_frame(frame_bytes.size(), end_stamp);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Light sender idling, heavy receiver idling
      sender_idle_pct   = 8;
      receiver_idle_pct = 50;
      // IPv4 with one option word, then IPv6, both captured
      send_full(ETH_TYPE_IPV4, 4'd6, PROTO_UDP, 16'd1000, match_port, 4, 64'd0);
      send_full(ETH_TYPE_IPV6, 4'd0, PROTO_UDP, match_port, 16'd5353, 2, rand64());
      // unknown EtherType, IHL below five, protocol neither UDP nor TCP, each cut short
      build_frame(ETH_TYPE_ARP, 4'd5, PROTO_UDP, match_port, match_port, 4);
      send_frame(16, rand64());
      build_frame(ETH_TYPE_IPV4, 4'd4, PROTO_UDP, match_port, match_port, 4);
      send_frame(18, rand64());
      build_frame(ETH_TYPE_IPV4, 4'd5, PROTO_ICMP, match_port, match_port, 4);
      send_frame(26, rand64());

      // Heavy sender idling, light receiver idling, on another match port
      write_match_port(16'hFFFF);
      sender_idle_pct   = 50;
      receiver_idle_pct = 8;
      // truncated inside the IP header, then a single-byte frame
      build_frame(ETH_TYPE_IPV4, 4'd5, PROTO_UDP, match_port, match_port, 4);
      send_frame(20, rand64());
      send_frame(1, rand64());
      // neither port matches, then a matching frame with no payload, which yields no record
      send_full(ETH_TYPE_IPV4, 4'd5, PROTO_UDP, 16'd1000, 16'd2000, 1, rand64());
      send_full(ETH_TYPE_IPV4, 4'd5, PROTO_UDP, match_port, match_port, 0, rand64());

      // No idling; hold the receiver off while a capture streams in, then let it drain
      write_match_port(16'($urandom));
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      stall_asked++;
      send_full(ETH_TYPE_IPV4, 4'd5, PROTO_TCP, match_port, 16'd80, 6, '1);

      wait_drained();
      if (mismatch_count == 0 && captures_outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
design/dpc_pkg.sv
design/dpc_parser.sv
design/dpc_out.sv
design/dns_packet_capture_parser.sv
dv/dpc_capture_checker.sv
dv/tb_dns_packet_capture_parser.sv
